// ----- src/irm_pkg.sv -----
// irm_pkg: widths, register map, configuration and beat types for the
// image rotation address mapper. No dependencies; used by every file in src.
package irm_pkg;

   // Image geometry and fixed point format
   localparam int MaxDim       = 4096;
   localparam int CoordW       = $clog2(MaxDim);      // source row / column
   localparam int DimW         = CoordW + 1;          // source width / height
   localparam int OutDimW      = DimW + 1;            // output width / height
   localparam int TrigFracBits = 16;
   localparam int TrigW        = TrigFracBits + 1;    // Q1.16 sine / cosine
   localparam int BppW         = 2;
   localparam int PixW         = 24;
   localparam int AddrW        = 28;

   // Datapath widths
   localparam int PosW  = DimW + 1;                   // signed turned coordinate
   localparam int ProdW = PosW + TrigW + 1;           // signed product
   localparam int SumW  = ProdW + 2;                  // signed fixed point sum
   localparam int RndW  = SumW - TrigFracBits + 1;    // signed rounded coordinate

   // Stream beat widths
   localparam int ReqDataW = ((2 * CoordW + PixW + 7) / 8) * 8;
   localparam int RspDataW = ((AddrW + PixW + 7) / 8) * 8;
   localparam int RspPadW  = RspDataW - AddrW - PixW;
   localparam int RspUserW = 1;

   // Register port
   localparam int NumRegs  = 8;
   localparam int RegIdxW  = $clog2(NumRegs);
   localparam int CsrAddrW = RegIdxW + 2;
   localparam int CsrDataW = 32;

   typedef enum logic [RegIdxW-1:0] {
      REG_SRC_WIDTH       = 3'd0,
      REG_SRC_HEIGHT      = 3'd1,
      REG_QUARTER_TURNS   = 3'd2,
      REG_FINE_COSINE     = 3'd3,
      REG_FINE_SINE       = 3'd4,
      REG_OUT_WIDTH       = 3'd5,
      REG_OUT_HEIGHT      = 3'd6,
      REG_BYTES_PER_PIXEL = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      TURN_0   = 2'd0,
      TURN_90  = 2'd1,
      TURN_180 = 2'd2,
      TURN_270 = 2'd3
   } turn_type;

   typedef struct packed {
      logic [DimW-1:0]    src_width;
      logic [DimW-1:0]    src_height;
      turn_type           quarter_turns;
      logic [TrigW-1:0]   fine_cosine;
      logic [TrigW-1:0]   fine_sine;
      logic [OutDimW-1:0] out_width;
      logic [OutDimW-1:0] out_height;
      logic [BppW-1:0]    bytes_per_pixel;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      src_width:       DimW'(1),
      src_height:      DimW'(1),
      quarter_turns:   TURN_0,
      fine_cosine:     TrigW'(1) << TrigFracBits,
      fine_sine:       '0,
      out_width:       OutDimW'(1),
      out_height:      OutDimW'(1),
      bytes_per_pixel: BppW'(3)
   };

   // Source pixel beat
   typedef struct packed {
      logic [PixW-1:0]   pixel;
      logic [CoordW-1:0] col;
      logic [CoordW-1:0] row;
   } src_type;

   // Rounded target coordinates; x and y are meaningful only when ok is set
   typedef struct packed {
      logic [PixW-1:0]    pixel;
      logic [OutDimW-1:0] x;
      logic [OutDimW-1:0] y;
      logic               ok;
   } rot_type;

   // Result beat
   typedef struct packed {
      logic [PixW-1:0]  pixel;
      logic [AddrW-1:0] addr;
      logic             ok;
   } rsp_type;

endpackage

// ----- src/image_rotation_address_mapper_unit.sv -----
// image_rotation_address_mapper_unit: top level of the forward-mapped image
// rotation address mapper. Depends on irm_pkg, irm_csr, irm_rotate, irm_address.
//
//   channel  | ports   | beat contents
//   ---------+---------+-----------------------------------------------
//   request  | req_*   | one source pixel: row, column, value
//   response | rsp_*   | byte address, pixel value, in-range flag
//   config   | csr_*   | APB-style, eight registers at 4*index
//
// Six register stages: quarter turns, products, sums, rounding and range
// check, pixel index, byte address. One beat per cycle is sustained
// whenever rsp_tready stays high.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults. A stall on rsp_tready backs up stage by stage; empty
// stages keep filling, so req_tready stays high until all six are full.
module image_rotation_address_mapper_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request: [11:0] src_row, [23:12] src_col, [47:24] pixel_in
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [irm_pkg::ReqDataW-1:0]   req_tdata,
   // response: [27:0] dest_address, [51:28] pixel_out, [55:52] zero
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [irm_pkg::RspDataW-1:0]   rsp_tdata,
   // response: [0] in_range
   output logic [irm_pkg::RspUserW-1:0]   rsp_tuser,
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [irm_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [irm_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [irm_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                           csr_pready
);

   localparam int CoordW = irm_pkg::CoordW;
   localparam int PixW   = irm_pkg::PixW;

   irm_pkg::cfg_type cfg;
   irm_pkg::src_type src;
   irm_pkg::rot_type rot;
   irm_pkg::rsp_type rsp;
   logic             rot_valid;
   logic             rot_ready;

   // Unpack request beat
   assign src.row   = req_tdata[CoordW-1:0];
   assign src.col   = req_tdata[2*CoordW-1:CoordW];
   assign src.pixel = req_tdata[2*CoordW+PixW-1:2*CoordW];

   irm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Quarter turns, fine rotation and rounding
   irm_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (src),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_data  (rot)
   );

   // Address; its last stage is the response register
   irm_address u_address (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_data   (rot),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {{irm_pkg::RspPadW{1'b0}}, rsp.pixel, rsp.addr};
   assign rsp_tuser = rsp.ok;

endmodule

// ----- src/irm_csr.sv -----
// irm_csr: APB-style register file holding the mapper configuration.
// Depends on irm_pkg.
module irm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [irm_pkg::CsrAddrW-1:0]  paddr,
   input  logic [irm_pkg::CsrDataW-1:0]  pwdata,
   output logic [irm_pkg::CsrDataW-1:0]  prdata,
   output logic                          pready,
   output irm_pkg::cfg_type              cfg
);

   irm_pkg::cfg_type     cfg_ff;
   irm_pkg::cfg_type     cfg_in;
   irm_pkg::reg_idx_type idx;
   logic                 wr_en;

   assign idx    = irm_pkg::reg_idx_type'(paddr[irm_pkg::CsrAddrW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            irm_pkg::REG_SRC_WIDTH:       cfg_in.src_width  = pwdata[irm_pkg::DimW-1:0];
            irm_pkg::REG_SRC_HEIGHT:      cfg_in.src_height = pwdata[irm_pkg::DimW-1:0];
            irm_pkg::REG_QUARTER_TURNS:   cfg_in.quarter_turns = irm_pkg::turn_type'(pwdata[1:0]);
            irm_pkg::REG_FINE_COSINE:     cfg_in.fine_cosine = pwdata[irm_pkg::TrigW-1:0];
            irm_pkg::REG_FINE_SINE:       cfg_in.fine_sine   = pwdata[irm_pkg::TrigW-1:0];
            irm_pkg::REG_OUT_WIDTH:       cfg_in.out_width   = pwdata[irm_pkg::OutDimW-1:0];
            irm_pkg::REG_OUT_HEIGHT:      cfg_in.out_height  = pwdata[irm_pkg::OutDimW-1:0];
            irm_pkg::REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = pwdata[irm_pkg::BppW-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         irm_pkg::REG_SRC_WIDTH:       prdata = irm_pkg::CsrDataW'(cfg_ff.src_width);
         irm_pkg::REG_SRC_HEIGHT:      prdata = irm_pkg::CsrDataW'(cfg_ff.src_height);
         irm_pkg::REG_QUARTER_TURNS:   prdata = irm_pkg::CsrDataW'(cfg_ff.quarter_turns);
         irm_pkg::REG_FINE_COSINE:     prdata = irm_pkg::CsrDataW'(cfg_ff.fine_cosine);
         irm_pkg::REG_FINE_SINE:       prdata = irm_pkg::CsrDataW'(cfg_ff.fine_sine);
         irm_pkg::REG_OUT_WIDTH:       prdata = irm_pkg::CsrDataW'(cfg_ff.out_width);
         irm_pkg::REG_OUT_HEIGHT:      prdata = irm_pkg::CsrDataW'(cfg_ff.out_height);
         irm_pkg::REG_BYTES_PER_PIXEL: prdata = irm_pkg::CsrDataW'(cfg_ff.bytes_per_pixel);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= irm_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/irm_rotate.sv -----
// irm_rotate: four pipeline stages - quarter turns, products, sums,
// round half to even with range check. Depends on irm_pkg.
module irm_rotate (
   input  logic               clock,
   input  logic               reset,
   input  irm_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  irm_pkg::src_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output irm_pkg::rot_type   out_data
);

   localparam int PosW  = irm_pkg::PosW;
   localparam int ProdW = irm_pkg::ProdW;
   localparam int SumW  = irm_pkg::SumW;
   localparam int RndW  = irm_pkg::RndW;
   localparam int FracB = irm_pkg::TrigFracBits;
   localparam int QW    = SumW - FracB;
   localparam int MagW  = RndW - 1;
   localparam int NumStages = 4;
   localparam int TrigW_S = irm_pkg::TrigW + 1;

   logic [NumStages-1:0] v_ff;
   logic [NumStages-1:0] rdy;

   // stage 1: turned coordinates
   logic signed [PosW-1:0]      row1_ff, row1_in, col1_ff, col1_in;
   logic [irm_pkg::DimW-1:0]    hf1_ff, hf1_in;
   logic [irm_pkg::PixW-1:0]    pix1_ff;
   // stage 2: products
   logic signed [ProdW-1:0]     pcc_ff, prs_ff, phs_ff, pcs_ff, prc_ff;
   logic signed [ProdW-1:0]     pcc_in, prs_in, phs_in, pcs_in, prc_in;
   logic [irm_pkg::PixW-1:0]    pix2_ff;
   // stage 3: fixed point sums
   logic signed [SumW-1:0]      xs_ff, ys_ff, xs_in, ys_in;
   logic [irm_pkg::PixW-1:0]    pix3_ff;
   // stage 4: rounded result
   irm_pkg::rot_type            rot_ff, rot_in;

   logic signed [PosW-1:0]      h_m1_r, w_m1_k, row_e, col_e;
   logic signed [TrigW_S-1:0]   cos_s, sin_s;
   logic signed [PosW-1:0]      hf_s;
   logic signed [RndW-1:0]      xr, yr;
   logic                        x_ok, y_ok;

   // Round n / 2^FracB to nearest, ties to even (floor based, symmetric)
   function automatic logic signed [RndW-1:0] round_even(input logic signed [SumW-1:0] n);
      logic signed [QW-1:0] q;
      logic [FracB-1:0]     rem;
      logic                 inc;
      q   = n[SumW-1:FracB];
      rem = n[FracB-1:0];
      inc = (rem > (FracB'(1) << (FracB - 1))) ||
            ((rem == (FracB'(1) << (FracB - 1))) && q[0]);
      return $signed({q[QW-1], q}) + $signed({{(RndW-1){1'b0}}, inc});
   endfunction

   // Ready ripples back; a stage takes a beat when empty or when it drains
   always_comb begin
      rdy[NumStages-1] = !v_ff[NumStages-1] || out_ready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NumStages-1];
   assign out_data  = rot_ff;

   // stage 1
   assign h_m1_r = $signed({1'b0, cfg.src_height} - PosW'(1) - PosW'(in_data.row));
   assign w_m1_k = $signed({1'b0, cfg.src_width}  - PosW'(1) - PosW'(in_data.col));
   assign row_e  = $signed(PosW'(in_data.row));
   assign col_e  = $signed(PosW'(in_data.col));

   always_comb begin
      case (cfg.quarter_turns)
         irm_pkg::TURN_0: begin
            row1_in = row_e;  col1_in = col_e;  hf1_in = cfg.src_height;
         end
         irm_pkg::TURN_90: begin
            row1_in = col_e;  col1_in = h_m1_r; hf1_in = cfg.src_width;
         end
         irm_pkg::TURN_180: begin
            row1_in = h_m1_r; col1_in = w_m1_k; hf1_in = cfg.src_height;
         end
         irm_pkg::TURN_270: begin
            row1_in = w_m1_k; col1_in = row_e;  hf1_in = cfg.src_width;
         end
         default: begin
            row1_in = row_e;  col1_in = col_e;  hf1_in = cfg.src_height;
         end
      endcase
   end

   // stage 2
   assign cos_s  = $signed({1'b0, cfg.fine_cosine});
   assign sin_s  = $signed({1'b0, cfg.fine_sine});
   assign hf_s   = $signed({1'b0, hf1_ff});
   assign pcc_in = ProdW'(col1_ff * cos_s);
   assign prs_in = ProdW'(row1_ff * sin_s);
   assign phs_in = ProdW'(hf_s * sin_s);
   assign pcs_in = ProdW'(col1_ff * sin_s);
   assign prc_in = ProdW'(row1_ff * cos_s);

   // stage 3
   assign xs_in = SumW'(pcc_ff) - SumW'(prs_ff) + SumW'(phs_ff);
   assign ys_in = SumW'(pcs_ff) + SumW'(prc_ff);

   // stage 4
   assign xr   = round_even(xs_ff);
   assign yr   = round_even(ys_ff);
   assign x_ok = !xr[RndW-1] && (xr[MagW-1:0] < MagW'(cfg.out_width));
   assign y_ok = !yr[RndW-1] && (yr[MagW-1:0] < MagW'(cfg.out_height));

   always_comb begin
      rot_in.pixel = pix3_ff;
      rot_in.x     = xr[irm_pkg::OutDimW-1:0];
      rot_in.y     = yr[irm_pkg::OutDimW-1:0];
      rot_in.ok    = x_ok && y_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NumStages; i++) begin
            if (rdy[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         row1_ff <= row1_in;
         col1_ff <= col1_in;
         hf1_ff  <= hf1_in;
         pix1_ff <= in_data.pixel;
      end
      if (rdy[1] && v_ff[0]) begin
         pcc_ff  <= pcc_in;
         prs_ff  <= prs_in;
         phs_ff  <= phs_in;
         pcs_ff  <= pcs_in;
         prc_ff  <= prc_in;
         pix2_ff <= pix1_ff;
      end
      if (rdy[2] && v_ff[1]) begin
         xs_ff   <= xs_in;
         ys_ff   <= ys_in;
         pix3_ff <= pix2_ff;
      end
      if (rdy[3] && v_ff[2]) begin
         rot_ff  <= rot_in;
      end
   end

endmodule

// ----- src/irm_address.sv -----
// irm_address: two pipeline stages forming the row-major byte address,
// out_width*y + x, then times bytes per pixel. Depends on irm_pkg.
module irm_address (
   input  logic               clock,
   input  logic               reset,
   input  irm_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  irm_pkg::rot_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output irm_pkg::rsp_type   out_data
);

   localparam int AddrW = irm_pkg::AddrW;
   localparam int NumStages = 2;

   logic [NumStages-1:0] v_ff;
   logic [NumStages-1:0] rdy;

   irm_pkg::rsp_type lin_ff, lin_in;
   irm_pkg::rsp_type rsp_ff, rsp_in;

   assign rdy[1]    = !v_ff[1] || out_ready;
   assign rdy[0]    = !v_ff[0] || rdy[1];
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[1];
   assign out_data  = rsp_ff;

   // Pixel index; zero when the target falls outside the output
   always_comb begin
      lin_in.pixel = in_data.pixel;
      lin_in.ok    = in_data.ok;
      lin_in.addr  = in_data.ok ?
                     AddrW'(cfg.out_width * in_data.y + AddrW'(in_data.x)) : '0;
   end

   always_comb begin
      rsp_in       = lin_ff;
      rsp_in.addr  = AddrW'(lin_ff.addr * cfg.bytes_per_pixel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) lin_ff <= lin_in;
      if (rdy[1] && v_ff[0])  rsp_ff <= rsp_in;
   end

endmodule

// ----- src/irm_checker.sv -----
// irm_checker: port-level assertions for the address mapper, bound to the
// top level. Depends on irm_pkg and image_rotation_address_mapper_unit.
module irm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [irm_pkg::RspDataW-1:0]   rsp_tdata,
   input logic [irm_pkg::RspUserW-1:0]   rsp_tuser
);

   // Stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed under stall");

   // Out-of-range beats carry a zero address
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[irm_pkg::AddrW-1:0] == '0)
      else $error("nonzero address on out-of-range beat");

   // Output stage free means every stage can move
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request stalled while response side drains");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind image_rotation_address_mapper_unit irm_checker u_irm_checker (.*);
